// ----- hdl/aesdec_pkg.sv -----
// aesdec_pkg: shared types, S-box tables and GF(2^8) helpers for the AES-128 decrypt unit.
// No dependencies.
package aesdec_pkg;

  localparam int unsigned ROUND_COUNT = 10;

  typedef logic [127:0] block_t;
  typedef logic [ROUND_COUNT:0][127:0] rk_array_t;
  typedef logic [3:0] round_idx_t;

  typedef enum logic [1:0] {
    KS_IDLE = 2'b01,
    KS_RUN  = 2'b10
  } ks_state_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // round constants for key expansion steps 1..10
  localparam logic [7:0] RCON [ROUND_COUNT] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // one InvMixColumns column, coefficients 14 11 13 9 rotated per row
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [31:0] res;
    for (int j = 0; j < 4; j++) begin
      a[j]   = col[31-8*j -: 8];
      x2[j]  = xtime(a[j]);
      x4[j]  = xtime(x2[j]);
      x8[j]  = xtime(x4[j]);
      m9[j]  = x8[j] ^ a[j];
      m11[j] = x8[j] ^ x2[j] ^ a[j];
      m13[j] = x8[j] ^ x4[j] ^ a[j];
      m14[j] = x8[j] ^ x4[j] ^ x2[j];
    end
    res[31:24] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
    res[23:16] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
    res[15:8]  = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
    res[7:0]   = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    return res;
  endfunction

  // AddRoundKey, optional InvMixColumns, InvShiftRows, InvSubBytes
  function automatic block_t inv_round(input block_t s, input block_t rk, input logic mix);
    block_t k;
    block_t m;
    block_t t;
    k = s ^ rk;
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = mix ? inv_mix_col(k[127-32*c -: 32]) : k[127-32*c -: 32];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = INV_SBOX[m[127-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  // one AES-128 key schedule step: round key n from round key n-1
  function automatic block_t key_step(input block_t p, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [31:0] n [4];
    for (int i = 0; i < 4; i++) begin
      w[i] = p[127-32*i -: 32];
    end
    t = {FWD_SBOX[w[3][23:16]] ^ rc, FWD_SBOX[w[3][15:8]],
         FWD_SBOX[w[3][7:0]], FWD_SBOX[w[3][31:24]]};
    n[0] = w[0] ^ t;
    n[1] = w[1] ^ n[0];
    n[2] = w[2] ^ n[1];
    n[3] = w[3] ^ n[2];
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

// ----- hdl/aesdec_key_exp.sv -----
// aesdec_key_exp: round-key store and sequencer, one schedule step per cycle.
// Depends on aesdec_pkg.
module aesdec_key_exp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  aesdec_pkg::block_t    key,
  output aesdec_pkg::rk_array_t rk,
  output logic                  busy
);
  import aesdec_pkg::*;

  ks_state_t  state;
  round_idx_t cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_RUN;
      cnt   <= round_idx_t'(1);
      rk[0] <= '0;
    end else if (load) begin
      state <= KS_RUN;
      cnt   <= round_idx_t'(1);
      rk[0] <= key;
    end else begin
      unique case (state)
        KS_IDLE: begin
        end
        KS_RUN: begin
          rk[cnt] <= key_step(rk[cnt - round_idx_t'(1)], RCON[cnt - round_idx_t'(1)]);
          if (cnt == round_idx_t'(ROUND_COUNT)) begin
            state <= KS_IDLE;
          end
          cnt <= cnt + round_idx_t'(1);
        end
        default: state <= KS_IDLE;
      endcase
    end
  end

  assign busy = (state == KS_RUN);

endmodule

// ----- hdl/aesdec_round.sv -----
// aesdec_round: one registered inverse-cipher round of the decrypt pipeline.
// Depends on aesdec_pkg.
module aesdec_round (
  input  logic               clk,
  input  logic               en,
  input  logic               mix,
  input  aesdec_pkg::block_t state_in,
  input  aesdec_pkg::block_t round_key,
  output aesdec_pkg::block_t state_out
);
  import aesdec_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= inv_round(state_in, round_key, mix);
    end
  end

endmodule

// ----- hdl/aes128_block_decrypt_unit.sv -----
// aes128_block_decrypt_unit: AES-128 ECB decrypt, fully unrolled ten-round pipeline.
// Depends on aesdec_pkg, aesdec_key_exp, aesdec_round.
//
//  channel   | signals                                        | direction
//  ----------+------------------------------------------------+----------
//  input     | in_valid, in_ready, ciphertext_high/low        | in
//  output    | out_valid, out_ready, plaintext_high/low       | out
//  config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB slave
//
// One block enters per cycle while in_ready is high. Eleven register stages (ten rounds plus the output
// register that adds round key 0); the accept edge loads the first, and out_valid
// rises as the output register takes the block from the tenth round stage.
// After reset the key schedule runs, one round key per cycle; after each key register
// write the key is loaded and the schedule runs again. in_ready is low then.
// Stalls freeze the whole pipeline together: when the output register holds an
// untaken transaction, no stage advances, so nothing is dropped or duplicated.
module aes128_block_decrypt_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] ciphertext_high,
  input  logic [63:0] ciphertext_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] plaintext_high,
  output logic [63:0] plaintext_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import aesdec_pkg::*;

  // configuration: key_high at 0x0, key_low at 0x8
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        cfg_wr;
  logic        key_load;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[3] ? key_low : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      key_load <= 1'b0;
    end else begin
      key_load <= cfg_wr;
      if (cfg_wr) begin
        if (paddr[3]) begin
          key_low <= pwdata;
        end else begin
          key_high <= pwdata;
        end
      end
    end
  end

  rk_array_t rk;
  logic      ks_busy;

  aesdec_key_exp u_key_exp (
    .clk  (clk),
    .rst  (rst),
    .load (key_load),
    .key  ({key_high, key_low}),
    .rk   (rk),
    .busy (ks_busy)
  );

  // global advance: every stage moves when the output slot is free or taken
  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en & ~ks_busy & ~key_load;

  block_t                  st [ROUND_COUNT];
  logic [ROUND_COUNT-1:0]  vld;

  // first stage: round key 10, no InvMixColumns
  aesdec_round u_round_first (
    .clk       (clk),
    .en        (en),
    .mix       (1'b0),
    .state_in  ({ciphertext_high, ciphertext_low}),
    .round_key (rk[ROUND_COUNT]),
    .state_out (st[0])
  );

  for (genvar k = 1; k < ROUND_COUNT; k++) begin : g_round
    aesdec_round u_round (
      .clk       (clk),
      .en        (en),
      .mix       (1'b1),
      .state_in  (st[k-1]),
      .round_key (rk[ROUND_COUNT-k]),
      .state_out (st[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[ROUND_COUNT-2:0], in_valid & in_ready};
      out_valid <= vld[ROUND_COUNT-1];
    end
  end

  // final AddRoundKey with round key 0
  always_ff @(posedge clk) begin
    if (en) begin
      {plaintext_high, plaintext_low} <= st[ROUND_COUNT-1] ^ rk[0];
    end
  end

  a_no_accept_during_ks: assert property (@(posedge clk) disable iff (rst)
    (ks_busy || key_load) |-> !in_ready)
    else $error("input accepted while key schedule runs");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !in_ready)
    else $error("input not held off after key write");

  a_last_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    (en && vld[ROUND_COUNT-1]) |=> out_valid)
    else $error("transaction lost at output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(plaintext_low)))
    else $error("stalled result changed");

endmodule

// ----- tb/aes128_block_decrypt_unit_tb.sv -----
// Testbench for aes128_block_decrypt_unit: AES-128 ECB decryption checked against an
// in-bench inverse cipher and key schedule. Depends on the DUT and aesdec_pkg only.
module aes128_block_decrypt_unit_tb;

  import aesdec_pkg::*;

  // register byte addresses: 64-bit registers on an 8-byte stride
  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] ciphertext_high;
  logic [63:0] ciphertext_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] plaintext_high;
  logic [63:0] plaintext_low;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes128_block_decrypt_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ciphertext_high(ciphertext_high), .ciphertext_low(ciphertext_low),
    .out_valid(out_valid), .out_ready(out_ready),
    .plaintext_high(plaintext_high), .plaintext_low(plaintext_low),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Bench-side cipher: own S-box tables, key copy and expanded schedule.
  // ---------------------------------------------------------------------------
  logic [7:0]  sbox [256];
  logic [7:0]  inv_sbox [256];
  logic [63:0] key_hi_shadow;
  logic [63:0] key_lo_shadow;
  logic [31:0] sched_words [44];

  // expected plaintext blocks, oldest first
  logic [127:0] plaintext_q [$];
  int unsigned  n_errors;
  int unsigned  sender_idle_pct;
  int unsigned  sink_stall_pct;

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // S-box from the field generator 3 and its inverse walk, plus the affine map
  task automatic build_sbox();
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] x;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ gf_double(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4);
      sbox[p] = x ^ 8'h63;
    end while (p != 8'h01);
    sbox[0] = 8'h63;
    for (int i = 0; i < 256; i++) inv_sbox[sbox[i]] = i[7:0];
  endtask

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched_words[0] = key_hi_shadow[63:32];
    sched_words[1] = key_hi_shadow[31:0];
    sched_words[2] = key_lo_shadow[63:32];
    sched_words[3] = key_lo_shadow[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_words[i-1];
      if (i % 4 == 0) begin
        t = {sbox[t[23:16]] ^ rc, sbox[t[15:8]], sbox[t[7:0]], sbox[t[31:24]]};
        rc = gf_double(rc);
      end
      sched_words[i] = sched_words[i-4] ^ t;
    end
  endtask

  function automatic logic [127:0] decrypt_block(input logic [127:0] ct);
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [31:0] w;
    logic [7:0]  acc;
    logic [7:0]  coef [4];
    logic [127:0] res;
    for (int i = 0; i < 16; i++) st[i] = ct[127-8*i -: 8];
    for (int r = 10; r >= 0; r--) begin
      // AddRoundKey
      for (int c = 0; c < 4; c++) begin
        w = sched_words[4*r + c];
        for (int row = 0; row < 4; row++) st[4*c+row] ^= w[31-8*row -: 8];
      end
      if (r == 0) break;
      // InvMixColumns in rounds 9..1
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int row = 0; row < 4; row++) begin
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
            acc = 8'h00;
            for (int j = 0; j < 4; j++) acc ^= gf_mul(st[4*c+j], coef[(j - row + 4) % 4]);
            tmp[4*c+row] = acc;
          end
        end
        st = tmp;
      end
      // InvShiftRows + InvSubBytes
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          tmp[4*c+row] = inv_sbox[st[4*((c - row + 4) % 4) + row]];
      st = tmp;
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the scoreboard check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    logic [127:0] exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (plaintext_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h_%h", $time,
                 plaintext_high, plaintext_low);
        n_errors++;
      end else begin
        exp_pt = plaintext_q.pop_front();
        if (plaintext_high !== exp_pt[127:64]) begin
          $display("%0t: plaintext_high expected %h actual %h", $time,
                   exp_pt[127:64], plaintext_high);
          n_errors++;
        end
        if (plaintext_low !== exp_pt[63:0]) begin
          $display("%0t: plaintext_low expected %h actual %h", $time,
                   exp_pt[63:0], plaintext_low);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task starts and ends on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    ciphertext_high <= hi;
    ciphertext_low  <= lo;
    // in_ready is stable by the falling edge; the next rising edge takes the transaction
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    plaintext_q.push_back(decrypt_block({hi, lo}));
  endtask

  // drain the pipeline so a key write never overlaps traffic
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (plaintext_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
    logic [63:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY_HIGH) key_hi_shadow = value;
    else key_lo_shadow = value;
    expand_schedule();
    // read it back
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      $display("%0t: key register %h readback expected %h actual %h", $time, addr, value, rd);
      n_errors++;
    end
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    wait_idle();
    write_key_reg(ADDR_KEY_HIGH, hi);
    write_key_reg(ADDR_KEY_LOW, lo);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // the reset key is all zeros; decrypt field extremes under it
  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
  endtask

  // published known-answer block, then the all-ones key
  task automatic test_known_vectors();
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    send_block('0, '1);
    load_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
  endtask

  // writing one half re-expands with the other half kept
  task automatic test_partial_key_update();
    wait_idle();
    write_key_reg(ADDR_KEY_HIGH, 64'h0);
    send_block(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888);
    send_block('1, '0);
    wait_idle();
    write_key_reg(ADDR_KEY_LOW, 64'hdead_beef_0bad_f00d);
    send_block(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888);
    send_block('0, '1);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    logic [63:0] hi;
    logic [63:0] lo;
    for (int i = 0; i < n; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(19))
        0: hi = '0;
        1: lo = '1;
        default: ;
      endcase
      send_block(hi, lo);
    end
  endtask

  task automatic set_pressure(input int unsigned idle_pct, input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    ciphertext_high = '0;
    ciphertext_low = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_errors = 0;
    set_pressure(0, 0);
    build_sbox();
    key_hi_shadow = '0;
    key_lo_shadow = '0;
    expand_schedule();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_known_vectors();
    test_partial_key_update();

    // random phases, each under a fresh random key
    set_pressure(0, 0);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    test_random_traffic(300);
    set_pressure(59, 0);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    test_random_traffic(300);
    set_pressure(0, 59);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    test_random_traffic(300);
    set_pressure(31, 31);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    test_random_traffic(300);

    in_valid <= 1'b0;
    @(posedge clk);
    while (plaintext_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(8 * 2000000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/aesdec_pkg.sv
hdl/aesdec_key_exp.sv
hdl/aesdec_round.sv
hdl/aes128_block_decrypt_unit.sv
tb/aes128_block_decrypt_unit_tb.sv
